// ----- rtl/cd_msf_lba_converter_top_assert.svh -----
// assertion macros for the cd msf / lba converter
`ifndef CD_MSF_LBA_CONVERTER_TOP_ASSERT_SVH
`define CD_MSF_LBA_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define CDMSF_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked on clk outside reset
`define CDMSF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/cdmsf_pkg.sv -----
// types, constants and helpers for the cd msf / lba converter
`timescale 1ns / 1ps

package cdmsf_pkg;

  localparam logic       CMD_MSF_TO_LBA = 1'b0;
  localparam logic       CMD_LBA_TO_MSF = 1'b1;

  localparam logic [7:0] LEADIN_FRAMES  = 8'd150;
  localparam logic [6:0] FRAMES_PER_SEC = 7'd75;
  localparam logic [5:0] SECS_PER_MIN   = 6'd60;
  localparam logic [6:0] MAX_MINUTES    = 7'd99;
  localparam logic [3:0] BCD_RADIX      = 4'd10;

  // reciprocals for exact division by constants over the value ranges used
  localparam logic [19:0] SEC_RECIP = 20'd894785;  // 2^26 / 75, rounded up
  localparam int          SEC_SHIFT = 26;
  localparam logic [13:0] MIN_RECIP = 14'd8739;    // 2^19 / 60, rounded up
  localparam int          MIN_SHIFT = 19;
  localparam logic [7:0]  DIG_RECIP = 8'd205;      // 2^11 / 10, rounded up
  localparam int          DIG_SHIFT = 11;

  typedef struct packed {
    logic              cmd;
    logic [7:0]        minute_in;
    logic [7:0]        second_in;
    logic [7:0]        frame_in;
    logic signed [19:0] block_in;
  } item_t;

  typedef struct packed {
    logic signed [21:0] block_out;
    logic [7:0]         minute_out;
    logic [6:0]         second_out;
    logic [6:0]         frame_out;
    logic               range_error;
  } result_t;

  // tens nibble times ten plus units nibble, nibbles above nine taken as is
  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    logic [7:0] tens;
    logic [7:0] units;
    tens  = {4'd0, b[7:4]};
    units = {4'd0, b[3:0]};
    return tens * {4'd0, BCD_RADIX} + units;
  endfunction

endpackage

// ----- rtl/cdmsf_bin2bcd.sv -----
// binary to two-digit bcd for values below 100
`timescale 1ns / 1ps

module cdmsf_bin2bcd
  import cdmsf_pkg::*;
(
  input  logic [6:0] value,
  output logic [7:0] bcd
);

  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  rest;

  assign prod = {8'd0, value} * {7'd0, DIG_RECIP};
  assign tens = prod[DIG_SHIFT +: 4];
  assign rest = value - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
  assign bcd  = {tens, rest[3:0]};

endmodule

// ----- rtl/cd_msf_lba_converter_top.sv -----
// top level of the cd msf / lba converter pipeline
`timescale 1ns / 1ps

// Converts CD addresses between BCD minute:second:sector and logical block
// numbers (block 0 = 150 frames in). cmd 0 decodes the BCD position to a
// block number; cmd 1 adds 150 to block_in and packs the result as BCD,
// flagging range_error for a negative position or more than 99 minutes.
// Five register stages, the last being the output register; one transaction
// is taken every cycle while no stall holds the stages. Each stage advances
// when the stage after it is empty or moving, so result_stall backs up through
// the stages and item_stall rises only once every stage holds a transaction.

`include "cd_msf_lba_converter_top_assert.svh"

module cd_msf_lba_converter_top
  import cdmsf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  // stage 1
  logic        cmd1, neg1;
  logic [7:0]  m1, s1, f1;
  logic [19:0] pos1;
  // stage 2
  logic        cmd2, neg2;
  logic [13:0] ms2;
  logic [7:0]  f2;
  logic [19:0] pos2;
  logic [12:0] q2;
  // stage 3
  logic        cmd3, neg3;
  logic [21:0] blk3;
  logic [6:0]  sect3;
  logic [12:0] q3;
  logic [25:0] prodm3;
  // stage 4
  logic        cmd4, neg4;
  logic [21:0] blk4;
  logic [6:0]  mins4;
  logic [5:0]  secs4;
  logic [7:0]  sect_bcd4;

  logic [20:0] pos_sum;
  logic [38:0] prod_sec;
  logic [26:0] prod_min;
  logic [19:0] rem_sec;
  logic [6:0]  mins_w;
  logic [12:0] secs_w;
  logic [7:0]  sect_bcd_w;
  logic [7:0]  mins_bcd_w;
  logic [7:0]  secs_bcd_w;
  logic        err_w;
  result_t     result_next;

  // stall chain
  assign en5 = !v5 || !result_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign item_stall   = !en1;
  assign result_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= item_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // stage 1: bcd decode, lead-in offset
  assign pos_sum = {item.block_in[19], item.block_in} + {13'd0, LEADIN_FRAMES};

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1 <= item.cmd;
      m1   <= bcd_decode(item.minute_in);
      s1   <= bcd_decode(item.second_in);
      f1   <= bcd_decode(item.frame_in);
      pos1 <= pos_sum[19:0];
      neg1 <= pos_sum[20];
    end
  end

  // stage 2: minutes to seconds, position divided by 75
  assign prod_sec = 39'({20'd0, pos1} * {20'd0, SEC_RECIP});

  always_ff @(posedge clk) begin
    if (en2) begin
      cmd2 <= cmd1;
      neg2 <= neg1;
      ms2  <= {6'd0, m1} * 14'(SECS_PER_MIN) + {6'd0, s1};
      f2   <= f1;
      pos2 <= pos1;
      q2   <= prod_sec[SEC_SHIFT +: 13];
    end
  end

  // stage 3: seconds to frames, sector remainder, total seconds divided by 60
  assign rem_sec  = pos2 - {7'd0, q2} * 20'(FRAMES_PER_SEC);
  assign prod_min = {14'd0, q2} * {13'd0, MIN_RECIP};

  always_ff @(posedge clk) begin
    if (en3) begin
      cmd3   <= cmd2;
      neg3   <= neg2;
      blk3   <= {8'd0, ms2} * 22'(FRAMES_PER_SEC) + {14'd0, f2} - {14'd0, LEADIN_FRAMES};
      sect3  <= rem_sec[6:0];
      q3     <= q2;
      prodm3 <= prod_min[25:0];
    end
  end

  // stage 4: minutes, second remainder, sector to bcd
  assign mins_w = prodm3[MIN_SHIFT +: 7];
  assign secs_w = q3 - 13'(mins_w) * 13'(SECS_PER_MIN);

  cdmsf_bin2bcd u_sect_bcd (
    .value (sect3),
    .bcd   (sect_bcd_w)
  );

  always_ff @(posedge clk) begin
    if (en4) begin
      cmd4      <= cmd3;
      neg4      <= neg3;
      blk4      <= blk3;
      mins4     <= mins_w;
      secs4     <= secs_w[5:0];
      sect_bcd4 <= sect_bcd_w;
    end
  end

  // stage 5: bcd pack, range check, output register
  cdmsf_bin2bcd u_mins_bcd (
    .value (mins4),
    .bcd   (mins_bcd_w)
  );

  cdmsf_bin2bcd u_secs_bcd (
    .value ({1'b0, secs4}),
    .bcd   (secs_bcd_w)
  );

  assign err_w = neg4 || (mins4 > MAX_MINUTES);

  always_comb begin
    result_next = '0;
    case (cmd4)
      CMD_MSF_TO_LBA: begin
        result_next.block_out = $signed(blk4);
      end
      CMD_LBA_TO_MSF: begin
        result_next.range_error = err_w;
        if (!err_w) begin
          result_next.minute_out = mins_bcd_w;
          result_next.second_out = secs_bcd_w[6:0];
          result_next.frame_out  = sect_bcd4[6:0];
        end
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      result <= result_next;
    end
  end

  `CDMSF_ASSERT_IMPL(a_err_clears_fields, result_valid && result.range_error,
    result.minute_out == 8'd0 && result.second_out == 7'd0 && result.frame_out == 7'd0
    && result.block_out == 22'sd0, "range error with nonzero fields")
  `CDMSF_ASSERT_IMPL(a_block_excludes_msf, result_valid && result.block_out != 22'sd0,
    result.minute_out == 8'd0 && result.second_out == 7'd0 && result.frame_out == 7'd0
    && !result.range_error, "block result mixed with msf fields")
  `CDMSF_ASSERT_IMPL(a_sector_in_range, v3 && cmd3 == CMD_LBA_TO_MSF && !neg3,
    sect3 < FRAMES_PER_SEC, "sector remainder out of range")
  `CDMSF_ASSERT_IMPL(a_second_in_range, v4 && cmd4 == CMD_LBA_TO_MSF && !neg4,
    secs4 < SECS_PER_MIN, "second remainder out of range")
  `CDMSF_ASSERT_NEXT(a_stage1_holds, v1 && !en2,
    v1 && $stable(cmd1) && $stable(pos1), "stalled stage 1 transaction lost")

endmodule
